>>> hw/rtl/hpd_pkg.sv
// Shared types and constants for the heatmap peak detector.
// Used by every module of the block; depends on nothing.
package hpd_pkg;

  localparam int COORD_W = 7;
  localparam int SCORE_W = 8;
  localparam int CFG_IDX_W = 3;

  localparam int DEF_MAX_GRID_W = 64;
  localparam int DEF_MAX_GRID_H = 64;
  localparam int DEF_MAX_CANDIDATES = 48;
  localparam int DEF_MAX_KEPT = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_POINT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_RAW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_WINDOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 3'd5;

  // One grid position with its raw score.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic signed [SCORE_W-1:0] score;
  } spot_t;

  // A finished frame handed from the front to the back.
  typedef struct packed {
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic signed [SCORE_W-1:0] mx;
  } job_t;

endpackage

>>> hw/rtl/heatmap_peak_detector.sv
// Top level of the heatmap peak detector: configuration registers and the
// front, queue and back. Depends on hpd_pkg, hpd_front, hpd_queue, hpd_back.
//
// Cells arrive on the cell channel (cell_valid, cell_stall, cell_score) in
// raster order, one transaction per cell, and are taken one per cycle while
// the block is collecting a frame. The transaction that completes a frame of
// grid_width by grid_height cells hands the frame to the back end; cell_stall
// then stays high until the back end has placed the last result of that frame
// in the output register. The back end scans the cells in raster order until
// the candidate list is full: it reads the center, skips each window position
// clipped by the grid edge and reads each in-grid neighbor (up to 48
// neighbors), with an early exit on a larger neighbor or a value below
// threshold, and records a candidate. It sorts the candidates by descending
// score, loads each sorted candidate and compares it with the kept peaks, and
// emits one result per cycle unless held. Results leave on the result channel
// (result_valid, result_stall); a stalled result holds and the back end waits.
// A frame with no peak yields one result with peak_valid low. The config
// channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready. Reset
// restores the register defaults and empties the frame.
module heatmap_peak_detector #(
  parameter int MAX_GRID_W = hpd_pkg::DEF_MAX_GRID_W,
  parameter int MAX_GRID_H = hpd_pkg::DEF_MAX_GRID_H,
  parameter int MAX_CANDIDATES = hpd_pkg::DEF_MAX_CANDIDATES,
  parameter int MAX_KEPT = hpd_pkg::DEF_MAX_KEPT
) (
  input  logic clk,
  input  logic rst,
  input  logic cell_valid,
  output logic cell_stall,
  input  logic signed [7:0] cell_score,
  output logic result_valid,
  input  logic result_stall,
  output logic [5:0] peak_x,
  output logic [5:0] peak_y,
  output logic signed [7:0] peak_score,
  output logic peak_valid,
  output logic signed [7:0] top_score,
  output logic last,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [hpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  localparam int DEPTH = MAX_GRID_W * MAX_GRID_H;
  localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam logic [8:0] MAXW9 = 9'(MAX_GRID_W);
  localparam logic [8:0] MAXH9 = 9'(MAX_GRID_H);

  logic [6:0] grid_width;
  logic [6:0] grid_height;
  logic signed [7:0] zero_point;
  logic signed [7:0] threshold_raw;
  logic [1:0] peak_window;
  logic [5:0] min_distance;

  logic [6:0] w_eff;
  logic [6:0] h_eff;
  logic back_busy;
  logic q_empty;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic signed [7:0] wr_data;
  logic push;
  logic pop;
  hpd_pkg::job_t push_job;
  hpd_pkg::job_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= 7'd16;
      grid_height <= 7'd16;
      zero_point <= '0;
      threshold_raw <= '0;
      peak_window <= 2'd1;
      min_distance <= 6'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hpd_pkg::REG_GRID_WIDTH: grid_width <= cfg_data[6:0];
        hpd_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data[6:0];
        hpd_pkg::REG_ZERO_POINT: zero_point <= cfg_data;
        hpd_pkg::REG_THRESHOLD_RAW: threshold_raw <= cfg_data;
        hpd_pkg::REG_PEAK_WINDOW: peak_window <= cfg_data[1:0];
        hpd_pkg::REG_MIN_DISTANCE: min_distance <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Grid dimensions are saturated to the range the store supports.
  assign w_eff = (grid_width == '0) ? 7'd1 :
                 ({2'b00, grid_width} > MAXW9) ? MAXW9[6:0] : grid_width;
  assign h_eff = (grid_height == '0) ? 7'd1 :
                 ({2'b00, grid_height} > MAXH9) ? MAXH9[6:0] : grid_height;

  hpd_front #(
    .MAX_GRID_W(MAX_GRID_W),
    .MAX_GRID_H(MAX_GRID_H)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cell_valid(cell_valid),
    .cell_stall(cell_stall),
    .cell_score(cell_score),
    .grid_w(w_eff),
    .grid_h(h_eff),
    .zero_point(zero_point),
    .back_busy(back_busy),
    .q_empty(q_empty),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .push(push),
    .push_job(push_job)
  );

  hpd_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_job(push_job),
    .pop(pop),
    .empty(q_empty),
    .head(head)
  );

  hpd_back #(
    .MAX_GRID_W(MAX_GRID_W),
    .MAX_GRID_H(MAX_GRID_H),
    .MAX_CANDIDATES(MAX_CANDIDATES),
    .MAX_KEPT(MAX_KEPT)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .job_valid(!q_empty),
    .job(head),
    .pop(pop),
    .busy(back_busy),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .threshold_raw(threshold_raw),
    .peak_window(peak_window),
    .min_distance(min_distance),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .peak_x(peak_x),
    .peak_y(peak_y),
    .peak_score(peak_score),
    .peak_valid(peak_valid),
    .top_score(top_score),
    .last(last)
  );

endmodule

>>> hw/rtl/hpd_front.sv
// Front of the peak detector: takes cells, writes them to the cell store,
// tracks the frame count and running maximum. Depends on hpd_pkg.
module hpd_front #(
  parameter int MAX_GRID_W = hpd_pkg::DEF_MAX_GRID_W,
  parameter int MAX_GRID_H = hpd_pkg::DEF_MAX_GRID_H
) (
  input  logic clk,
  input  logic rst,
  input  logic cell_valid,
  output logic cell_stall,
  input  logic signed [hpd_pkg::SCORE_W-1:0] cell_score,
  input  logic [hpd_pkg::COORD_W-1:0] grid_w,
  input  logic [hpd_pkg::COORD_W-1:0] grid_h,
  input  logic signed [hpd_pkg::SCORE_W-1:0] zero_point,
  input  logic back_busy,
  input  logic q_empty,
  output logic wr_en,
  output logic [((MAX_GRID_W*MAX_GRID_H) > 1 ? $clog2(MAX_GRID_W*MAX_GRID_H) : 1)-1:0] wr_addr,
  output logic signed [hpd_pkg::SCORE_W-1:0] wr_data,
  output logic push,
  output hpd_pkg::job_t push_job
);
  localparam int DEPTH = MAX_GRID_W * MAX_GRID_H;
  localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int FW = (CW + 1) > 14 ? (CW + 1) : 14;

  logic [CW-1:0] cell_counter;
  logic signed [hpd_pkg::SCORE_W-1:0] running_max;
  logic signed [hpd_pkg::SCORE_W-1:0] rm_new;
  logic [FW-1:0] frame_size;
  logic [FW-1:0] count_inc;
  logic accept;
  logic done;

  // The store is shared with the back, so a new frame waits for it.
  assign cell_stall = !q_empty || back_busy;
  assign accept = cell_valid && !cell_stall;
  assign rm_new = (cell_score > running_max) ? cell_score : running_max;
  assign frame_size = FW'(grid_w) * FW'(grid_h);
  assign count_inc = FW'(cell_counter) + FW'(1);
  assign done = accept && (count_inc >= frame_size);

  assign wr_en = accept && (FW'(cell_counter) < FW'(DEPTH));
  assign wr_addr = cell_counter[AW-1:0];
  assign wr_data = cell_score;
  assign push = done;
  assign push_job.w = grid_w;
  assign push_job.h = grid_h;
  assign push_job.mx = (rm_new > zero_point) ? rm_new : zero_point;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_counter <= '0;
      running_max <= '0;
    end else if (accept) begin
      if (done) begin
        cell_counter <= '0;
        running_max <= zero_point;
      end else begin
        cell_counter <= cell_counter + CW'(1);
        running_max <= rm_new;
      end
    end
  end

endmodule

>>> hw/rtl/hpd_queue.sv
// Two-entry queue of finished frames between the front and the back.
// Depends on hpd_pkg for the job type.
module hpd_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  hpd_pkg::job_t push_job,
  input  logic pop,
  output logic empty,
  output hpd_pkg::job_t head
);
  hpd_pkg::job_t entries [2];
  logic rd_ptr;
  logic wr_ptr;
  logic [1:0] count;
  logic do_push;
  logic do_pop;

  assign empty = (count == 2'd0);
  assign head = entries[rd_ptr];
  assign do_push = push && (count != 2'd2);
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

endmodule

>>> hw/rtl/hpd_back.sv
// Back of the peak detector: holds the cell store, scans for local maxima,
// sorts candidates, suppresses near peaks and emits results. Depends on hpd_pkg.
module hpd_back #(
  parameter int MAX_GRID_W = hpd_pkg::DEF_MAX_GRID_W,
  parameter int MAX_GRID_H = hpd_pkg::DEF_MAX_GRID_H,
  parameter int MAX_CANDIDATES = hpd_pkg::DEF_MAX_CANDIDATES,
  parameter int MAX_KEPT = hpd_pkg::DEF_MAX_KEPT
) (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  input  hpd_pkg::job_t job,
  output logic pop,
  output logic busy,
  input  logic wr_en,
  input  logic [((MAX_GRID_W*MAX_GRID_H) > 1 ? $clog2(MAX_GRID_W*MAX_GRID_H) : 1)-1:0] wr_addr,
  input  logic signed [hpd_pkg::SCORE_W-1:0] wr_data,
  input  logic signed [hpd_pkg::SCORE_W-1:0] threshold_raw,
  input  logic [1:0] peak_window,
  input  logic [5:0] min_distance,
  output logic result_valid,
  input  logic result_stall,
  output logic [5:0] peak_x,
  output logic [5:0] peak_y,
  output logic signed [hpd_pkg::SCORE_W-1:0] peak_score,
  output logic peak_valid,
  output logic signed [hpd_pkg::SCORE_W-1:0] top_score,
  output logic last
);
  localparam int DEPTH = MAX_GRID_W * MAX_GRID_H;
  localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CAW = MAX_CANDIDATES > 1 ? $clog2(MAX_CANDIDATES) : 1;
  localparam int CCW = $clog2(MAX_CANDIDATES + 1);
  localparam int KAW = MAX_KEPT > 1 ? $clog2(MAX_KEPT) : 1;
  localparam int KCW = $clog2(MAX_KEPT + 1);
  localparam int CW = hpd_pkg::COORD_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CTR_RD, S_CTR_CHK, S_NB, S_NB_CHK, S_ADD,
    S_SORT_START, S_SORT_RI, S_SORT_LI, S_SORT_RJ, S_SORT_CJ, S_SORT_WI,
    S_SEL_RD, S_SEL_LD, S_SEL_CMP, S_EMIT
  } state_t;

  state_t state;
  hpd_pkg::job_t job_r;
  logic [CW-1:0] sx;
  logic [CW-1:0] sy;
  logic signed [2:0] dx;
  logic signed [2:0] dy;
  logic signed [hpd_pkg::SCORE_W-1:0] cv;
  logic [CCW-1:0] ccnt;
  logic [CAW-1:0] ci;
  logic [CAW-1:0] cj;
  hpd_pkg::spot_t cur;
  hpd_pkg::spot_t cand;
  logic [KCW-1:0] kcnt;
  logic [KAW-1:0] kk;
  logic [KAW-1:0] eidx;
  hpd_pkg::spot_t kept [MAX_KEPT];

  logic signed [hpd_pkg::SCORE_W-1:0] cell_mem [DEPTH];
  logic signed [hpd_pkg::SCORE_W-1:0] cell_rd;
  logic [AW-1:0] cell_raddr;
  hpd_pkg::spot_t cand_mem [MAX_CANDIDATES];
  hpd_pkg::spot_t cand_rd;
  logic [CAW-1:0] cra;
  logic cwe;
  logic [CAW-1:0] cwa;
  hpd_pkg::spot_t cwd;

  // Scan helpers.
  logic signed [2:0] pws;
  logic signed [2:0] negpw;
  logic signed [8:0] nx;
  logic signed [8:0] ny;
  logic nb_ok;
  logic nb_last;
  logic signed [2:0] dx_adv;
  logic signed [2:0] dy_adv;
  logic col_end;
  logic scan_end;
  logic [CW-1:0] row_sel;
  logic [CW-1:0] col_sel;
  logic [13:0] addr_full;

  // Suppression helpers.
  hpd_pkg::spot_t kp;
  logic [CW-1:0] adx;
  logic [CW-1:0] ady;
  logic [CW-1:0] cheb;
  logic far;
  logic out_free;
  logic emit_last;

  assign pws = $signed({1'b0, peak_window});
  assign negpw = -pws;
  assign nx = $signed({2'b00, sx}) + $signed({{6{dx[2]}}, dx});
  assign ny = $signed({2'b00, sy}) + $signed({{6{dy[2]}}, dy});
  assign nb_ok = !nx[8] && (nx[7:0] < {1'b0, job_r.w}) &&
                 !ny[8] && (ny[7:0] < {1'b0, job_r.h}) &&
                 !((dx == 3'sd0) && (dy == 3'sd0));
  assign nb_last = (dx == pws) && (dy == pws);
  assign dx_adv = (dx == pws) ? negpw : dx + 3'sd1;
  assign dy_adv = (dx == pws) ? dy + 3'sd1 : dy;
  assign col_end = (sx == job_r.w - CW'(1));
  assign scan_end = col_end && (sy == job_r.h - CW'(1));

  assign row_sel = (state == S_NB) ? ny[CW-1:0] : sy;
  assign col_sel = (state == S_NB) ? nx[CW-1:0] : sx;
  assign addr_full = 14'(row_sel) * 14'(job_r.w) + 14'(col_sel);
  assign cell_raddr = AW'(addr_full);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cell_mem[wr_addr] <= wr_data;
    end
    cell_rd <= cell_mem[cell_raddr];
  end

  // Candidate list port selection.
  always_comb begin
    cra = ci;
    cwe = 1'b0;
    cwa = ci;
    cwd = cur;
    case (state)
      S_SORT_RJ: cra = cj;
      S_ADD: begin
        cwe = 1'b1;
        cwa = ccnt[CAW-1:0];
        cwd = '{x: sx, y: sy, score: cv};
      end
      S_SORT_CJ: begin
        cwe = (cand_rd.score > cur.score);
        cwa = cj;
        cwd = cur;
      end
      S_SORT_WI: begin
        cwe = 1'b1;
        cwa = ci;
        cwd = cur;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cwe) begin
      cand_mem[cwa] <= cwd;
    end
    cand_rd <= cand_mem[cra];
  end

  assign kp = kept[kk];
  assign adx = (kp.x > cand.x) ? kp.x - cand.x : cand.x - kp.x;
  assign ady = (kp.y > cand.y) ? kp.y - cand.y : cand.y - kp.y;
  assign cheb = (adx > ady) ? adx : ady;
  assign far = cheb > {1'b0, min_distance};

  assign out_free = !result_valid || !result_stall;
  assign emit_last = (kcnt == '0) || ((KCW+1)'(eidx) + (KCW+1)'(1) == (KCW+1)'(kcnt));
  assign busy = (state != S_IDLE);
  assign pop = (state == S_IDLE) && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
      ccnt <= '0;
      kcnt <= '0;
    end else begin
      if (out_free) result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            job_r <= job;
            sx <= '0;
            sy <= '0;
            ccnt <= '0;
            kcnt <= '0;
            eidx <= '0;
            state <= S_CTR_RD;
          end
        end
        S_CTR_RD: state <= S_CTR_CHK;
        S_CTR_CHK: begin
          cv <= cell_rd;
          if (cell_rd < threshold_raw) begin
            if (scan_end) state <= S_SORT_START;
            else begin
              sx <= col_end ? '0 : sx + CW'(1);
              sy <= col_end ? sy + CW'(1) : sy;
              state <= S_CTR_RD;
            end
          end else begin
            dx <= negpw;
            dy <= negpw;
            state <= S_NB;
          end
        end
        S_NB: begin
          if (nb_ok) state <= S_NB_CHK;
          else if (nb_last) state <= S_ADD;
          else begin
            dx <= dx_adv;
            dy <= dy_adv;
          end
        end
        S_NB_CHK: begin
          if (cell_rd > cv) begin
            if (scan_end) state <= S_SORT_START;
            else begin
              sx <= col_end ? '0 : sx + CW'(1);
              sy <= col_end ? sy + CW'(1) : sy;
              state <= S_CTR_RD;
            end
          end else if (nb_last) begin
            state <= S_ADD;
          end else begin
            dx <= dx_adv;
            dy <= dy_adv;
            state <= S_NB;
          end
        end
        S_ADD: begin
          ccnt <= ccnt + CCW'(1);
          if (((CCW+1)'(ccnt) + (CCW+1)'(1) == (CCW+1)'(MAX_CANDIDATES)) || scan_end) begin
            state <= S_SORT_START;
          end else begin
            sx <= col_end ? '0 : sx + CW'(1);
            sy <= col_end ? sy + CW'(1) : sy;
            state <= S_CTR_RD;
          end
        end
        S_SORT_START: begin
          ci <= '0;
          if (ccnt == '0) state <= S_EMIT;
          else if (ccnt == CCW'(1)) state <= S_SEL_RD;
          else state <= S_SORT_RI;
        end
        S_SORT_RI: state <= S_SORT_LI;
        S_SORT_LI: begin
          cur <= cand_rd;
          cj <= ci + CAW'(1);
          state <= S_SORT_RJ;
        end
        S_SORT_RJ: state <= S_SORT_CJ;
        S_SORT_CJ: begin
          // A strictly greater later score trades places with the held one.
          if (cand_rd.score > cur.score) cur <= cand_rd;
          if ((CCW+1)'(cj) + (CCW+1)'(1) < (CCW+1)'(ccnt)) begin
            cj <= cj + CAW'(1);
            state <= S_SORT_RJ;
          end else begin
            state <= S_SORT_WI;
          end
        end
        S_SORT_WI: begin
          if ((CCW+1)'(ci) + (CCW+1)'(2) < (CCW+1)'(ccnt)) begin
            ci <= ci + CAW'(1);
            state <= S_SORT_RI;
          end else begin
            ci <= '0;
            state <= S_SEL_RD;
          end
        end
        S_SEL_RD: state <= S_SEL_LD;
        S_SEL_LD: begin
          cand <= cand_rd;
          kk <= '0;
          state <= S_SEL_CMP;
        end
        S_SEL_CMP: begin
          if ((kcnt == '0) || (far && ((KCW+1)'(kk) + (KCW+1)'(1) == (KCW+1)'(kcnt)))) begin
            kept[kcnt[KAW-1:0]] <= cand;
            kcnt <= kcnt + KCW'(1);
            if ((KCW+1)'(kcnt) + (KCW+1)'(1) == (KCW+1)'(MAX_KEPT)) state <= S_EMIT;
            else if ((CCW+1)'(ci) + (CCW+1)'(1) < (CCW+1)'(ccnt)) begin
              ci <= ci + CAW'(1);
              state <= S_SEL_RD;
            end else state <= S_EMIT;
          end else if (far) begin
            kk <= kk + KAW'(1);
          end else if ((CCW+1)'(ci) + (CCW+1)'(1) < (CCW+1)'(ccnt)) begin
            ci <= ci + CAW'(1);
            state <= S_SEL_RD;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            top_score <= job_r.mx;
            last <= emit_last;
            if (kcnt == '0) begin
              peak_x <= '0;
              peak_y <= '0;
              peak_score <= '0;
              peak_valid <= 1'b0;
            end else begin
              peak_x <= kept[eidx].x[5:0];
              peak_y <= kept[eidx].y[5:0];
              peak_score <= kept[eidx].score;
              peak_valid <= 1'b1;
            end
            if (emit_last) state <= S_IDLE;
            else eidx <= eidx + KAW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ccnt_bound: assert property (@(posedge clk) disable iff (rst)
    (CCW+1)'(ccnt) <= (CCW+1)'(MAX_CANDIDATES))
    else $error("candidate count past its limit");

  a_kcnt_bound: assert property (@(posedge clk) disable iff (rst)
    (KCW+1)'(kcnt) <= (KCW+1)'(MAX_KEPT))
    else $error("kept peak count past its limit");

  a_emit_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && kcnt != '0) |-> ((KCW+1)'(eidx) < (KCW+1)'(kcnt)))
    else $error("emit index beyond kept peaks");

endmodule
